### sv/afr_pkg.sv
// ----------------------------------------------------------------------------
// Air/fuel ramp controller package
// Shared control codes, register indexes and the command/status bundles.
// ----------------------------------------------------------------------------
package afr_pkg;

    localparam int DIV_STEPS = 14;
    localparam int DIV_CNT_W = 4;

    localparam logic [1:0] MODE_AUTO    = 2'd0;
    localparam logic [1:0] MODE_LOWFIRE = 2'd1;
    localparam logic [1:0] MODE_MANUAL  = 2'd2;

    localparam logic [2:0] CFG_MODE      = 3'd0;
    localparam logic [2:0] CFG_DUAL_FUEL = 3'd1;
    localparam logic [2:0] CFG_SET_POINT = 3'd2;
    localparam logic [2:0] CFG_MANUAL    = 3'd3;
    localparam logic [2:0] CFG_PILOT_GAS = 3'd4;
    localparam logic [2:0] CFG_PILOT_OIL = 3'd5;
    localparam logic [2:0] CFG_GAS_LIM   = 3'd6;
    localparam logic [2:0] CFG_OIL_LIM   = 3'd7;

    typedef struct packed {
        logic capture;
        logic wr_point;
        logic trim;
        logic pid;
        logic rd_en;
        logic ld_first;
        logic ld_last;
        logic ramp;
        logic ld_lim;
        logic ld_prev;
        logic mul;
        logic div_step;
        logic fix;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic       func;
        logic [1:0] mode;
        logic       err_small;
        logic       lim_hit;
        logic       seg_match;
        logic       out_free;
    } t_stat;

endpackage

### sv/air_fuel_ratio_ramp_controller_core.sv
// A curve write, trim tick or idle-mode tick goes from decode straight to the result register;
// a ramp tick stops after the limit check when the duty hits a limit, scans every curve
// segment when no segment matches, and with interpolation also runs the 14-step restoring
// divider and a fix-up step before the result registers.
// Throughput: one request at a time; the next is taken the cycle after the result registers,
// and a stalled result holds it off. Synchronous active-low reset; curve points get none.
// ----------------------------------------------------------------------------
// Air/fuel ratio ramp controller core
// Burner air duty ramp, O2 trim and air-to-fuel curve interpolation.
// ----------------------------------------------------------------------------
module air_fuel_ratio_ramp_controller_core #(
    parameter int CURVE_POINTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes, always ready
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [15:0] i_process_pressure,
    input  logic [7:0]  i_o2_level,
    input  logic [6:0]  i_pid_demand,
    input  logic        i_curve_select,
    input  logic [2:0]  i_point_index,
    input  logic [6:0]  i_point_air,
    input  logic [6:0]  i_point_fuel,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [6:0]  o_air_duty,
    output logic [6:0]  o_fuel_position,
    output logic        o_trimming,
    output logic        o_pid_active
);
    import afr_pkg::*;

    t_cmd                            cmd;
    t_stat                           stat;
    logic [$clog2(CURVE_POINTS)-1:0] rd_idx;

    // registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    // sequencer: decode the request, walk the curve, run the divider
    afr_ctrl #(
        .CURVE_POINTS(CURVE_POINTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_rd_idx   (rd_idx)
    );

    // datapath: holds registers, curve memory and result register
    afr_datapath #(
        .CURVE_POINTS(CURVE_POINTS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_func             (i_func),
        .i_process_pressure (i_process_pressure),
        .i_o2_level         (i_o2_level),
        .i_pid_demand       (i_pid_demand),
        .i_curve_select     (i_curve_select),
        .i_point_index      (i_point_index),
        .i_point_air        (i_point_air),
        .i_point_fuel       (i_point_fuel),
        .i_cmd              (cmd),
        .i_rd_idx           (rd_idx),
        .o_stat             (stat),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_air_duty         (o_air_duty),
        .o_fuel_position    (o_fuel_position),
        .o_trimming         (o_trimming),
        .o_pid_active       (o_pid_active)
    );

endmodule

### sv/afr_datapath.sv
// ----------------------------------------------------------------------------
// Air/fuel ramp datapath
// Registers, curve memory, ramp/trim arithmetic, multiplier and divider.
// ----------------------------------------------------------------------------
module afr_datapath #(
    parameter int CURVE_POINTS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [2:0]                        i_cfg_index,
    input  logic [31:0]                       i_cfg_data,
    input  logic                              i_func,
    input  logic [15:0]                       i_process_pressure,
    input  logic [7:0]                        i_o2_level,
    input  logic [6:0]                        i_pid_demand,
    input  logic                              i_curve_select,
    input  logic [2:0]                        i_point_index,
    input  logic [6:0]                        i_point_air,
    input  logic [6:0]                        i_point_fuel,
    input  afr_pkg::t_cmd                     i_cmd,
    input  logic [$clog2(CURVE_POINTS)-1:0]   i_rd_idx,
    output afr_pkg::t_stat                    o_stat,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [6:0]                        o_air_duty,
    output logic [6:0]                        o_fuel_position,
    output logic                              o_trimming,
    output logic                              o_pid_active
);
    import afr_pkg::*;

    localparam int AW = $clog2(2 * CURVE_POINTS);

    logic [1:0]  r_mode;
    logic        r_dual;
    logic [15:0] r_set_point;
    logic [6:0]  r_manual, r_pilot_gas, r_pilot_oil;
    logic [31:0] r_gas_lim, r_oil_lim;

    logic        r_func, r_sel;
    logic [15:0] r_pp;
    logic [7:0]  r_o2;
    logic [6:0]  r_pid_dem, r_pa, r_pf;
    logic [2:0]  r_idx;

    logic [6:0]  r_duty, r_fuel;
    logic [2:0]  r_up_cnt, r_dn_cnt;
    logic        r_trimming, r_pid;

    logic [13:0] mem [0:2*CURVE_POINTS-1];
    logic [13:0] r_rd;
    logic [6:0]  r_first, r_last, r_prev_a, r_prev_f;
    logic        r_neg;
    logic [6:0]  r_den;
    logic [7:0]  r_rem;
    logic [13:0] r_quo;

    logic        r_ov;
    logic [6:0]  r_o_duty, r_o_fuel;
    logic        r_o_trim, r_o_pid;

    logic [AW-1:0] wr_addr, rd_addr;
    logic          wr_ok;
    logic [15:0]   err;
    logic [6:0]    tgt, step, floor_v;
    logic [7:0]    ramp_nd, trim_dn;
    logic [6:0]    ramp_duty, trim_duty;
    logic [31:0]   lim;
    logic          lim_hi, lim_lo;
    logic [7:0]    lim_byte;
    logic [6:0]    fuel_lim;
    logic [6:0]    rd_a, rd_f;
    logic [7:0]    dfs;
    logic [6:0]    dmag, dx;
    logic [13:0]   prod;
    logic [7:0]    div_t, fix_v;

    // curve memory: gas points first, oil points after
    assign wr_addr = r_sel  ? AW'(CURVE_POINTS) + AW'(r_idx)    : AW'(r_idx);
    assign rd_addr = r_dual ? AW'(CURVE_POINTS) + AW'(i_rd_idx) : AW'(i_rd_idx);
    assign wr_ok   = 32'(r_idx) < 32'(CURVE_POINTS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_point && wr_ok) begin
            mem[wr_addr] <= {r_pa, r_pf};
        end
        if (i_cmd.rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    assign rd_a = r_rd[13:7];
    assign rd_f = r_rd[6:0];

    assign err = (r_pp > r_set_point) ? r_pp - r_set_point : r_set_point - r_pp;

    // ramp toward target, clamp to curve ends
    always_comb begin
        case (r_mode)
            MODE_AUTO:    tgt = r_pid_dem;
            MODE_LOWFIRE: tgt = r_first;
            default:      tgt = r_manual;
        endcase
        ramp_nd   = {1'b0, r_duty};
        ramp_duty = r_duty;
        step      = 7'd0;
        if (r_duty < tgt) begin
            step      = ((tgt - r_duty) <= 7'd5) ? 7'd1 : (((tgt - r_duty) <= 7'd10) ? 7'd5 : 7'd10);
            ramp_nd   = {1'b0, r_duty} + {1'b0, step};
            ramp_duty = (ramp_nd >= {1'b0, r_last}) ? r_last : ramp_nd[6:0];
        end else if (r_duty > tgt) begin
            step      = ((r_duty - tgt) <= 7'd5) ? 7'd1 : (((r_duty - tgt) <= 7'd10) ? 7'd5 : 7'd10);
            ramp_nd   = {1'b0, r_duty} - {1'b0, step};
            ramp_duty = (ramp_nd <= {1'b0, r_first}) ? r_first : ramp_nd[6:0];
        end
    end

    assign floor_v   = r_dual ? r_pilot_oil : r_pilot_gas;
    assign trim_dn   = {1'b0, r_duty} - 8'd1;
    assign trim_duty = ($signed(trim_dn) <= $signed({1'b0, floor_v})) ? floor_v : trim_dn[6:0];

    assign lim      = r_dual ? r_oil_lim : r_gas_lim;
    assign lim_hi   = {1'b0, r_duty} >= lim[15:8];
    assign lim_lo   = {1'b0, r_duty} <= lim[7:0];
    assign lim_byte = lim_hi ? lim[31:24] : lim[23:16];
    assign fuel_lim = lim_byte[7] ? 7'd127 : lim_byte[6:0];

    assign dfs   = {1'b0, rd_f} - {1'b0, r_prev_f};
    assign dmag  = dfs[7] ? 7'(-dfs) : dfs[6:0];
    assign dx    = r_duty - r_prev_a;
    assign prod  = {7'd0, dx} * {7'd0, dmag};
    assign div_t = {r_rem[6:0], r_quo[13]};
    assign fix_v = r_neg ? {1'b0, r_prev_f} - {1'b0, r_quo[6:0]}
                         : {1'b0, r_prev_f} + {1'b0, r_quo[6:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_MANUAL;
            r_dual      <= 1'b0;
            r_set_point <= 16'd0;
            r_manual    <= 7'd0;
            r_pilot_gas <= 7'd0;
            r_pilot_oil <= 7'd0;
            r_gas_lim   <= 32'h6400_6400;
            r_oil_lim   <= 32'h6400_6400;
            r_duty      <= 7'd0;
            r_fuel      <= 7'd0;
            r_up_cnt    <= 3'd0;
            r_dn_cnt    <= 3'd0;
            r_trimming  <= 1'b0;
            r_pid       <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MODE:      r_mode      <= i_cfg_data[1:0];
                    CFG_DUAL_FUEL: r_dual      <= i_cfg_data[0];
                    CFG_SET_POINT: r_set_point <= i_cfg_data[15:0];
                    CFG_MANUAL:    r_manual    <= i_cfg_data[6:0];
                    CFG_PILOT_GAS: r_pilot_gas <= i_cfg_data[6:0];
                    CFG_PILOT_OIL: r_pilot_oil <= i_cfg_data[6:0];
                    CFG_GAS_LIM:   r_gas_lim   <= i_cfg_data;
                    CFG_OIL_LIM:   r_oil_lim   <= i_cfg_data;
                    default:       r_mode      <= r_mode;
                endcase
            end
            if (i_cmd.capture) begin
                r_trimming <= 1'b0;
                r_pid      <= 1'b0;
            end
            if (i_cmd.trim) begin
                r_trimming <= 1'b1;
                if (r_o2 < 8'd2) begin
                    if (r_up_cnt < 3'd6) begin
                        r_up_cnt <= r_up_cnt + 3'd1;
                        r_duty   <= (r_duty >= 7'd98) ? 7'd99 : r_duty + 7'd1;
                    end
                end else if (r_o2 > 8'd4) begin
                    if (r_dn_cnt < 3'd6) begin
                        r_dn_cnt <= r_dn_cnt + 3'd1;
                        r_duty   <= trim_duty;
                    end
                end
            end
            if (i_cmd.pid) begin
                r_pid    <= 1'b1;
                r_up_cnt <= 3'd0;
                r_dn_cnt <= 3'd0;
            end
            if (i_cmd.ramp) begin
                r_duty <= ramp_duty;
            end
            if (i_cmd.ld_lim) begin
                r_fuel <= fuel_lim;
            end
            if (i_cmd.fix) begin
                r_fuel <= fix_v[6:0];
            end
            if (i_cmd.load_out) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func    <= i_func;
            r_pp      <= i_process_pressure;
            r_o2      <= i_o2_level;
            r_pid_dem <= i_pid_demand;
            r_sel     <= i_curve_select;
            r_idx     <= i_point_index;
            r_pa      <= i_point_air;
            r_pf      <= i_point_fuel;
        end
        if (i_cmd.ld_first) begin
            r_first <= rd_a;
        end
        if (i_cmd.ld_last) begin
            r_last <= rd_a;
        end
        if (i_cmd.ld_prev) begin
            r_prev_a <= rd_a;
            r_prev_f <= rd_f;
        end
        if (i_cmd.mul) begin
            r_neg <= dfs[7];
            r_den <= rd_a - r_prev_a;
            r_rem <= 8'd0;
            r_quo <= prod;
        end
        if (i_cmd.div_step) begin
            if (div_t >= {1'b0, r_den}) begin
                r_rem <= div_t - {1'b0, r_den};
                r_quo <= {r_quo[12:0], 1'b1};
            end else begin
                r_rem <= div_t;
                r_quo <= {r_quo[12:0], 1'b0};
            end
        end
        if (i_cmd.load_out) begin
            r_o_duty <= r_duty;
            r_o_fuel <= r_fuel;
            r_o_trim <= r_trimming;
            r_o_pid  <= r_pid;
        end
    end

    assign o_stat.func      = r_func;
    assign o_stat.mode      = r_mode;
    assign o_stat.err_small = err <= 16'd3;
    assign o_stat.lim_hit   = lim_hi | lim_lo;
    assign o_stat.seg_match = (r_duty >= r_prev_a) && (r_duty < rd_a);
    assign o_stat.out_free  = !r_ov || !i_out_stall;

    assign o_out_valid     = r_ov;
    assign o_air_duty      = r_o_duty;
    assign o_fuel_position = r_o_fuel;
    assign o_trimming      = r_o_trim;
    assign o_pid_active    = r_o_pid;

endmodule

### sv/afr_ctrl.sv
// ----------------------------------------------------------------------------
// Air/fuel ramp controller sequencer
// Steps the datapath through write, trim, ramp, curve scan and divide.
// ----------------------------------------------------------------------------
module afr_ctrl #(
    parameter int CURVE_POINTS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  afr_pkg::t_stat                  i_stat,
    output afr_pkg::t_cmd                   o_cmd,
    output logic [$clog2(CURVE_POINTS)-1:0] o_rd_idx
);
    import afr_pkg::*;

    localparam int IW = $clog2(CURVE_POINTS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_FIRST = 4'd2;
    localparam logic [3:0] S_LAST  = 4'd3;
    localparam logic [3:0] S_RAMP  = 4'd4;
    localparam logic [3:0] S_LIMIT = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_FIX   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]           r_state, n_state;
    logic [IW-1:0]        r_k, n_k;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_cnt    = r_cnt;
        o_cmd    = '0;
        o_rd_idx = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.func) begin
                    o_cmd.wr_point = 1'b1;
                    n_state        = S_OUT;
                end else if (i_stat.mode == MODE_AUTO && i_stat.err_small) begin
                    o_cmd.trim = 1'b1;
                    n_state    = S_OUT;
                end else if (i_stat.mode == MODE_AUTO || i_stat.mode == MODE_LOWFIRE
                             || i_stat.mode == MODE_MANUAL) begin
                    o_cmd.pid   = (i_stat.mode == MODE_AUTO);
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_FIRST;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_FIRST: begin
                o_cmd.ld_first = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_rd_idx       = IW'(CURVE_POINTS - 1);
                n_state        = S_LAST;
            end
            S_LAST: begin
                o_cmd.ld_last = 1'b1;
                n_state       = S_RAMP;
            end
            S_RAMP: begin
                o_cmd.ramp  = 1'b1;
                o_cmd.rd_en = 1'b1;
                n_state     = S_LIMIT;
            end
            S_LIMIT: begin
                if (i_stat.lim_hit) begin
                    o_cmd.ld_lim = 1'b1;
                    n_state      = S_OUT;
                end else begin
                    o_cmd.ld_prev = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    o_rd_idx      = IW'(1);
                    n_k           = IW'(1);
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.seg_match) begin
                    o_cmd.mul = 1'b1;
                    n_cnt     = '0;
                    n_state   = S_DIV;
                end else if (r_k == IW'(CURVE_POINTS - 1)) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.ld_prev = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    o_rd_idx      = r_k + IW'(1);
                    n_k           = r_k + IW'(1);
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
